>>> rtl/core/rgbw_pkg.sv
`default_nettype none
package rgbw_pkg;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FWD  = 4'b0010,
    S_SRCH = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  localparam logic [0:0]  OP_FWD     = 1'b0;
  localparam logic [0:0]  OP_REV     = 1'b1;
  localparam logic [11:0] DUTY_TOP   = 12'h0fff;
  localparam logic [7:0]  LEVEL_TOP  = 8'd255;
  localparam logic [7:0]  LEVEL_MID  = 8'd127;
  localparam logic [3:0]  SRCH_LAST  = 4'd15;
  localparam logic [1:0]  CH_WHITE   = 2'd3;

  localparam logic [11:0] GAMMA_ROM [256] = '{
    12'h000,12'h001,12'h002,12'h003,12'h004,12'h005,12'h006,12'h007,
    12'h008,12'h009,12'h00a,12'h00b,12'h00c,12'h00d,12'h00e,12'h00f,
    12'h010,12'h011,12'h012,12'h013,12'h014,12'h015,12'h016,12'h017,
    12'h018,12'h019,12'h01a,12'h01b,12'h01c,12'h01d,12'h01e,12'h01f,
    12'h020,12'h021,12'h022,12'h023,12'h024,12'h025,12'h026,12'h027,
    12'h028,12'h02a,12'h02d,12'h02f,12'h032,12'h035,12'h038,12'h03b,
    12'h03e,12'h042,12'h045,12'h049,12'h04c,12'h050,12'h054,12'h058,
    12'h05c,12'h060,12'h065,12'h069,12'h06d,12'h072,12'h077,12'h07c,
    12'h081,12'h086,12'h08b,12'h090,12'h096,12'h09b,12'h0a1,12'h0a7,
    12'h0ad,12'h0b3,12'h0b9,12'h0c0,12'h0c6,12'h0cd,12'h0d3,12'h0da,
    12'h0e1,12'h0e8,12'h0f0,12'h0f7,12'h0ff,12'h106,12'h10e,12'h116,
    12'h11e,12'h126,12'h12f,12'h137,12'h140,12'h148,12'h151,12'h15a,
    12'h164,12'h16d,12'h176,12'h180,12'h18a,12'h194,12'h19e,12'h1a8,
    12'h1b2,12'h1bd,12'h1c8,12'h1d3,12'h1de,12'h1e9,12'h1f4,12'h1ff,
    12'h20b,12'h217,12'h223,12'h22f,12'h23b,12'h247,12'h254,12'h261,
    12'h26e,12'h27b,12'h288,12'h295,12'h2a3,12'h2b0,12'h2be,12'h2cc,
    12'h2db,12'h2e9,12'h2f7,12'h306,12'h315,12'h324,12'h333,12'h343,
    12'h352,12'h362,12'h372,12'h382,12'h392,12'h3a3,12'h3b3,12'h3c4,
    12'h3d5,12'h3e6,12'h3f7,12'h409,12'h41a,12'h42c,12'h43e,12'h450,
    12'h463,12'h475,12'h488,12'h49b,12'h4ae,12'h4c2,12'h4d5,12'h4e9,
    12'h4fd,12'h511,12'h525,12'h539,12'h54e,12'h563,12'h578,12'h58d,
    12'h5a2,12'h5b8,12'h5ce,12'h5e3,12'h5fa,12'h610,12'h626,12'h63d,
    12'h654,12'h66b,12'h683,12'h69a,12'h6b2,12'h6ca,12'h6e2,12'h6fa,
    12'h713,12'h72b,12'h744,12'h75d,12'h777,12'h790,12'h7aa,12'h7c4,
    12'h7de,12'h7f8,12'h813,12'h82e,12'h849,12'h864,12'h87f,12'h89b,
    12'h8b6,12'h8d2,12'h8ef,12'h90b,12'h928,12'h944,12'h961,12'h97f,
    12'h99c,12'h9ba,12'h9d8,12'h9f6,12'ha14,12'ha33,12'ha52,12'ha71,
    12'ha90,12'haaf,12'hacf,12'haef,12'hb0f,12'hb2f,12'hb4f,12'hb70,
    12'hb91,12'hbb2,12'hbd4,12'hbf5,12'hc17,12'hc39,12'hc5b,12'hc7e,
    12'hca1,12'hcc4,12'hce7,12'hd0a,12'hd2e,12'hd52,12'hd76,12'hd9a,
    12'hdbf,12'hde3,12'he08,12'he2e,12'he53,12'he79,12'he9f,12'hec5,
    12'heeb,12'hf12,12'hf39,12'hf60,12'hf87,12'hfaf,12'hfd6,12'hfff
  };

endpackage
`default_nettype wire

>>> rtl/core/rgbw_gamma_duty_converter.sv
// Forward word: one table read per channel. Reverse word: each channel is a
// binary search of one table read and compare per cycle.
// One word at a time: busy high from accept until done.
// Reset (rst, synchronous): sequencer to idle, busy and done low.
// The receiver cannot stall; done is a single-cycle strobe.
`default_nettype none
module rgbw_gamma_duty_converter
  import rgbw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic        operation,
  input  wire logic [7:0]  red_in,
  input  wire logic [7:0]  green_in,
  input  wire logic [7:0]  blue_in,
  input  wire logic [11:0] duty_red_in,
  input  wire logic [11:0] duty_green_in,
  input  wire logic [11:0] duty_blue_in,
  input  wire logic [11:0] duty_white_in,
  output logic [11:0]      duty_red,
  output logic [11:0]      duty_green,
  output logic [11:0]      duty_blue,
  output logic [11:0]      duty_white,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out
);

  state_t      state;
  logic        op;
  logic [1:0]  ch;
  logic [7:0]  lvl [4];
  logic [11:0] dty [4];
  logic [11:0] duty_res [4];
  logic [7:0]  lev_res [4];
  logic [7:0]  lo, hi, probe;
  logic [3:0]  n;

  logic        accept;
  logic [7:0]  w_min;
  logic [7:0]  rom_addr;
  logic [11:0] rom_q;
  logic [11:0] dsel;
  logic [7:0]  lo_next, hi_next, probe_next;
  logic        srch_end;
  logic [7:0]  srch_val;
  logic [8:0]  sum_r, sum_g, sum_b;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_comb begin
    w_min = red_in;
    if (green_in < w_min) w_min = green_in;
    if (blue_in < w_min) w_min = blue_in;
  end

  // single shared table port
  assign rom_addr = (state == S_FWD) ? lvl[ch] : probe;
  assign rom_q    = GAMMA_ROM[rom_addr];
  assign dsel     = dty[ch];

  always_comb begin
    lo_next    = lo;
    hi_next    = hi;
    srch_end   = 1'b0;
    srch_val   = probe;
    if (rom_q > dsel) begin
      hi_next = probe;
    end else begin
      lo_next = probe;
    end
    probe_next = lo_next + ((hi_next - lo_next) >> 1);
    if (dsel >= DUTY_TOP) begin
      srch_end = 1'b1;
      srch_val = LEVEL_TOP;
    end else if (lo == probe || rom_q == dsel) begin
      srch_end = 1'b1;
    end else if (n == SRCH_LAST) begin
      // search bound reached after this step
      srch_end = 1'b1;
      srch_val = probe_next;
    end
  end

  assign sum_r = {1'b0, lev_res[0]} + {1'b0, lev_res[CH_WHITE]};
  assign sum_g = {1'b0, lev_res[1]} + {1'b0, lev_res[CH_WHITE]};
  assign sum_b = {1'b0, lev_res[2]} + {1'b0, lev_res[CH_WHITE]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (operation == OP_REV) ? S_SRCH : S_FWD;
          end
        end
        S_FWD: begin
          if (ch == CH_WHITE) state <= S_DONE;
        end
        S_SRCH: begin
          if (srch_end && ch == CH_WHITE) state <= S_DONE;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op     <= operation;
          ch     <= 2'd0;
          lvl[0] <= red_in - w_min;
          lvl[1] <= green_in - w_min;
          lvl[2] <= blue_in - w_min;
          lvl[3] <= w_min;
          dty[0] <= duty_red_in;
          dty[1] <= duty_green_in;
          dty[2] <= duty_blue_in;
          dty[3] <= duty_white_in;
          lo     <= 8'd0;
          probe  <= LEVEL_MID;
          hi     <= LEVEL_TOP;
          n      <= 4'd0;
        end
      end
      S_FWD: begin
        duty_res[ch] <= rom_q;
        ch           <= ch + 2'd1;
      end
      S_SRCH: begin
        if (srch_end) begin
          lev_res[ch] <= srch_val;
          ch          <= ch + 2'd1;
          lo          <= 8'd0;
          probe       <= LEVEL_MID;
          hi          <= LEVEL_TOP;
          n           <= 4'd0;
        end else begin
          lo    <= lo_next;
          hi    <= hi_next;
          probe <= probe_next;
          n     <= n + 4'd1;
        end
      end
      S_DONE: begin
        if (op == OP_REV) begin
          duty_red   <= 12'd0;
          duty_green <= 12'd0;
          duty_blue  <= 12'd0;
          duty_white <= 12'd0;
          red_out    <= sum_r[8] ? LEVEL_TOP : sum_r[7:0];
          green_out  <= sum_g[8] ? LEVEL_TOP : sum_g[7:0];
          blue_out   <= sum_b[8] ? LEVEL_TOP : sum_b[7:0];
        end else begin
          duty_red   <= duty_res[0];
          duty_green <= duty_res[1];
          duty_blue  <= duty_res[2];
          duty_white <= duty_res[3];
          red_out    <= 8'd0;
          green_out  <= 8'd0;
          blue_out   <= 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_after_done_state: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DONE)) else $error("done without finishing state");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted word did not raise busy");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |-> (lo <= probe && probe <= hi))
    else $error("search probe outside bounds");

  a_fwd_levels_zero: assert property (@(posedge clk) disable iff (rst)
    (done && op == OP_FWD) |-> (red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0))
    else $error("forward word with non-zero levels");
`endif

endmodule
`default_nettype wire
